[rtl/core/latency_sample_percentile_stats_assert.svh]
// Assertion macros shared by the statistics block.
`ifndef LATENCY_SAMPLE_PERCENTILE_STATS_ASSERT_SVH
`define LATENCY_SAMPLE_PERCENTILE_STATS_ASSERT_SVH
`ifndef SYNTH
`define LSPS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsps assertion failed");
`define LSPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsps assertion failed");
`else
`define LSPS_ASSERT_SAME(lbl, ante, cons)
`define LSPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/lsps_pkg.sv]
package lsps_pkg;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int PCT_W    = 7;
    localparam int STAT_W   = 2;
    localparam int ANS_W    = 48;
    localparam int CNT_W    = 13;
    localparam int SUM_W    = 45;
    localparam int FRAC_W   = 16;
    localparam int PHASE_W  = 16;
    localparam int DEND_W   = SUM_W + FRAC_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int PCT_DIVISOR = 100;

    // Division by 100 as a multiply by ceil(2^32 / 100) and a shift by 32.
    // The result is exact for every product of a percent and a fill count.
    localparam int RECIP_W         = 26;
    localparam int PCT_RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 26'd42949673;

    localparam logic [KIND_W-1:0] KIND_PKT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEAN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PCT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] STAT_SKIP    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_STORED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DROP    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ANSWER  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_EVERY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 8'd1;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 13'd4096;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SELECT,
        ST_EXT_SCAN,
        ST_PIV_RD,
        ST_PIV_LATCH,
        ST_CNT_SCAN,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SCAN_MIN,
        SCAN_MAX,
        SCAN_COUNT
    } scan_mode_t;

    typedef enum logic [2:0] {
        OSEL_PKT,
        OSEL_NONE,
        OSEL_ZERO,
        OSEL_MEAN,
        OSEL_BEST,
        OSEL_PIVOT
    } out_sel_t;

    typedef struct packed {
        logic       pkt_step;
        logic       out_load;
        out_sel_t   out_sel;
        logic       div_start;
        logic       div_pct;
        logic       outer_clr;
        logic       outer_inc;
        logic       piv_latch;
        logic       scan_start;
        scan_mode_t scan_mode;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic n_zero;
        logic k_zero;
        logic k_ge_n;
        logic div_busy;
        logic scan_busy;
        logic hit;
    } stat_t;

endpackage

[rtl/core/lsps_if.sv]
interface lsps_in_if;
    logic                             valid;
    logic                             ready;
    logic [lsps_pkg::KIND_W-1:0]      kind;
    logic [lsps_pkg::WORD_W-1:0]      latency_word;
    logic [lsps_pkg::PCT_W-1:0]       query_percent;

    modport source (output valid, kind, latency_word, query_percent, input ready);
    modport sink (input valid, kind, latency_word, query_percent, output ready);
endinterface

interface lsps_out_if;
    logic                             valid;
    logic                             ready;
    logic [lsps_pkg::STAT_W-1:0]      status;
    logic [lsps_pkg::ANS_W-1:0]       answer_value;
    logic [lsps_pkg::CNT_W-1:0]       stored_count;

    modport source (output valid, status, answer_value, stored_count, input ready);
    modport sink (input valid, status, answer_value, stored_count, output ready);
endinterface

interface lsps_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lsps_pkg::CFG_IDX_W-1:0]   index;
    logic [lsps_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/lsps_ctrl.sv]
module lsps_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [lsps_pkg::KIND_W-1:0]  in_kind,
    output logic                         in_ready,
    input  lsps_pkg::stat_t              stat,
    output lsps_pkg::cmd_t               cmd
);

    lsps_pkg::state_t   state_reg, state_next;
    lsps_pkg::out_sel_t sel_reg, sel_next;
    logic               pct_reg, pct_next;
    logic               in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsps_pkg::ST_IDLE;
            sel_reg   <= lsps_pkg::OSEL_NONE;
            pct_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            pct_reg   <= pct_next;
        end
    end

    assign in_ready = (state_reg == lsps_pkg::ST_IDLE) && stat.out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        pct_next       = pct_reg;
        cmd            = '0;
        cmd.out_sel    = sel_reg;
        cmd.scan_mode  = lsps_pkg::SCAN_COUNT;
        case (state_reg)
            lsps_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_kind)
                        lsps_pkg::KIND_PKT:
                        begin
                            cmd.pkt_step = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = lsps_pkg::OSEL_PKT;
                        end
                        lsps_pkg::KIND_MEAN, lsps_pkg::KIND_PCT:
                        begin
                            if (stat.n_zero)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = lsps_pkg::OSEL_ZERO;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                cmd.div_pct   = (in_kind == lsps_pkg::KIND_PCT);
                                pct_next      = (in_kind == lsps_pkg::KIND_PCT);
                                state_next    = lsps_pkg::ST_DIV;
                            end
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = lsps_pkg::OSEL_NONE;
                        end
                    endcase
                end
            end
            lsps_pkg::ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    if (pct_reg)
                    begin
                        state_next = lsps_pkg::ST_SELECT;
                    end
                    else
                    begin
                        sel_next   = lsps_pkg::OSEL_MEAN;
                        state_next = lsps_pkg::ST_DONE;
                    end
                end
            end
            lsps_pkg::ST_SELECT:
            begin
                if (stat.k_zero)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = lsps_pkg::SCAN_MIN;
                    state_next     = lsps_pkg::ST_EXT_SCAN;
                end
                else if (stat.k_ge_n)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = lsps_pkg::SCAN_MAX;
                    state_next     = lsps_pkg::ST_EXT_SCAN;
                end
                else
                begin
                    cmd.outer_clr = 1'b1;
                    state_next    = lsps_pkg::ST_PIV_RD;
                end
            end
            lsps_pkg::ST_EXT_SCAN:
            begin
                if (!stat.scan_busy)
                begin
                    sel_next   = lsps_pkg::OSEL_BEST;
                    state_next = lsps_pkg::ST_DONE;
                end
            end
            lsps_pkg::ST_PIV_RD:
            begin
                state_next = lsps_pkg::ST_PIV_LATCH;
            end
            lsps_pkg::ST_PIV_LATCH:
            begin
                cmd.piv_latch  = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = lsps_pkg::ST_CNT_SCAN;
            end
            lsps_pkg::ST_CNT_SCAN:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = lsps_pkg::ST_CHECK;
                end
            end
            lsps_pkg::ST_CHECK:
            begin
                if (stat.hit)
                begin
                    sel_next   = lsps_pkg::OSEL_PIVOT;
                    state_next = lsps_pkg::ST_DONE;
                end
                else
                begin
                    cmd.outer_inc = 1'b1;
                    state_next    = lsps_pkg::ST_PIV_RD;
                end
            end
            lsps_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lsps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/lsps_datapath.sv]
module lsps_datapath
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lsps_pkg::WORD_W-1:0]      in_word,
    input  logic [lsps_pkg::PCT_W-1:0]       in_pct,
    input  logic                             cfg_valid,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  lsps_pkg::cmd_t                   cmd,
    output lsps_pkg::stat_t                  stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lsps_pkg::STAT_W-1:0]      out_status,
    output logic [lsps_pkg::ANS_W-1:0]       out_answer,
    output logic [lsps_pkg::CNT_W-1:0]       out_count
);

    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CMPW   = (CW > lsps_pkg::CNT_W) ? CW : lsps_pkg::CNT_W;
    localparam int DVW    = (CW > lsps_pkg::PCT_W) ? CW : lsps_pkg::PCT_W;
    localparam int DEND_W = lsps_pkg::DEND_W;
    localparam int DCNT_W = $clog2(DEND_W + 1);
    localparam int PRODW  = lsps_pkg::PCT_W + CW;
    localparam int RPW    = PRODW + lsps_pkg::RECIP_W;

    logic [lsps_pkg::PHASE_W-1:0] every_reg;
    logic [lsps_pkg::CNT_W-1:0]   cap_reg;
    logic [lsps_pkg::PHASE_W-1:0] phase_reg;
    logic [CW-1:0]                fill_reg, fill_next;
    logic [lsps_pkg::SUM_W-1:0]   sum_reg;
    logic [lsps_pkg::WORD_W-1:0]  mem [MAX_SAMPLES];
    logic [lsps_pkg::WORD_W-1:0]  rd_data_reg;
    logic [AW-1:0]                rd_addr;

    logic [lsps_pkg::PHASE_W:0]   phase_inc;
    logic [lsps_pkg::PHASE_W:0]   period;
    logic                         take;
    logic                         full;
    logic                         store;
    logic [lsps_pkg::STAT_W-1:0]  pkt_status;

    logic [DEND_W-1:0]            dend_reg;
    logic [DVW-1:0]               rem_reg;
    logic [DVW-1:0]               divisor_reg;
    logic [DCNT_W-1:0]            dcnt_reg;
    logic                         pct_mode_reg;
    logic [DVW:0]                 rem_sh;
    logic                         rem_ge;
    logic [PRODW-1:0]             product;
    logic [RPW-1:0]               recip_prod;
    logic [CW:0]                  k_val;

    logic                         scan_act_reg;
    logic                         scan_pend_reg;
    logic [AW-1:0]                scan_addr_reg;
    logic [AW-1:0]                scan_last;
    lsps_pkg::scan_mode_t         mode_reg;
    logic [lsps_pkg::WORD_W-1:0]  best_reg;
    logic [lsps_pkg::WORD_W-1:0]  pivot_reg;
    logic [CW-1:0]                below_reg;
    logic [CW-1:0]                upto_reg;
    logic [AW-1:0]                outer_reg;
    logic [CW-1:0]                fill_dec;

    logic                         out_valid_reg;
    logic [lsps_pkg::STAT_W-1:0]  out_status_reg;
    logic [lsps_pkg::ANS_W-1:0]   out_answer_reg;
    logic [lsps_pkg::CNT_W-1:0]   out_count_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            every_reg <= lsps_pkg::PHASE_W'(1);
            cap_reg   <= lsps_pkg::CAPACITY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lsps_pkg::REG_SAMPLE_EVERY:   every_reg <= cfg_data;
                lsps_pkg::REG_CAPACITY_LIMIT: cap_reg   <= cfg_data[lsps_pkg::CNT_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Packet sampling and store.
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign period    = (every_reg == '0) ? (lsps_pkg::PHASE_W+1)'(1) : {1'b0, every_reg};
    assign take      = (phase_reg == '0);
    assign full      = (CMPW'(fill_reg) >= CMPW'(cap_reg))
                       || (CMPW'(fill_reg) >= CMPW'(MAX_SAMPLES));
    assign store     = take && !full;
    assign fill_next = store ? fill_reg + 1'b1 : fill_reg;

    always_comb
    begin
        if (!take)
        begin
            pkt_status = lsps_pkg::STAT_SKIP;
        end
        else if (full)
        begin
            pkt_status = lsps_pkg::STAT_DROP;
        end
        else
        begin
            pkt_status = lsps_pkg::STAT_STORED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.pkt_step)
        begin
            phase_reg <= (phase_inc >= period) ? '0 : phase_inc[lsps_pkg::PHASE_W-1:0];
            fill_reg  <= fill_next;
            if (store)
            begin
                sum_reg <= sum_reg + lsps_pkg::SUM_W'(in_word);
            end
        end
    end

    assign rd_addr = scan_act_reg ? scan_addr_reg : outer_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pkt_step && store)
        begin
            mem[fill_reg[AW-1:0]] <= in_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Restoring divider for the mean, one quotient bit per cycle. The rank
    // of a percentile query is formed through a reciprocal multiply.
    assign product    = PRODW'(in_pct) * PRODW'(fill_reg);
    assign recip_prod = RPW'(dend_reg[PRODW-1:0]) * RPW'(lsps_pkg::PCT_RECIP);
    assign rem_sh     = {rem_reg, dend_reg[DEND_W-1]};
    assign rem_ge     = (rem_sh >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= cmd.div_pct ? DCNT_W'(1) : DCNT_W'(DEND_W);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg      <= '0;
            pct_mode_reg <= cmd.div_pct;
            if (cmd.div_pct)
            begin
                dend_reg <= DEND_W'(product);
            end
            else
            begin
                dend_reg    <= {sum_reg, {lsps_pkg::FRAC_W{1'b0}}};
                divisor_reg <= DVW'(fill_reg);
            end
        end
        else if (dcnt_reg != '0)
        begin
            if (pct_mode_reg)
            begin
                dend_reg <= DEND_W'(recip_prod[RPW-1:lsps_pkg::PCT_RECIP_SHIFT]);
            end
            else
            begin
                rem_reg  <= rem_ge ? DVW'(rem_sh - {1'b0, divisor_reg}) : rem_sh[DVW-1:0];
                dend_reg <= {dend_reg[DEND_W-2:0], rem_ge};
            end
        end
    end

    assign k_val = dend_reg[CW:0];

    // Sequential scan over the stored samples.
    assign fill_dec  = fill_reg - 1'b1;
    assign scan_last = fill_dec[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_act_reg  <= 1'b0;
            scan_pend_reg <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= scan_act_reg;
            if (cmd.scan_start)
            begin
                scan_act_reg <= 1'b1;
            end
            else if (scan_act_reg && (scan_addr_reg == scan_last))
            begin
                scan_act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_addr_reg <= '0;
            mode_reg      <= cmd.scan_mode;
            best_reg      <= (cmd.scan_mode == lsps_pkg::SCAN_MIN) ? '1 : '0;
            below_reg     <= '0;
            upto_reg      <= '0;
        end
        else
        begin
            if (scan_act_reg)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (scan_pend_reg)
            begin
                case (mode_reg)
                    lsps_pkg::SCAN_MIN:
                    begin
                        if (rd_data_reg < best_reg)
                        begin
                            best_reg <= rd_data_reg;
                        end
                    end
                    lsps_pkg::SCAN_MAX:
                    begin
                        if (rd_data_reg > best_reg)
                        begin
                            best_reg <= rd_data_reg;
                        end
                    end
                    default:
                    begin
                        if (rd_data_reg < pivot_reg)
                        begin
                            below_reg <= below_reg + 1'b1;
                        end
                        if (rd_data_reg <= pivot_reg)
                        begin
                            upto_reg <= upto_reg + 1'b1;
                        end
                    end
                endcase
            end
        end
        if (cmd.outer_clr)
        begin
            outer_reg <= '0;
        end
        else if (cmd.outer_inc)
        begin
            outer_reg <= outer_reg + 1'b1;
        end
        if (cmd.piv_latch)
        begin
            pivot_reg <= rd_data_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_count_reg <= (cmd.out_sel == lsps_pkg::OSEL_PKT) ? lsps_pkg::CNT_W'(fill_next)
                                                                 : lsps_pkg::CNT_W'(fill_reg);
            case (cmd.out_sel)
                lsps_pkg::OSEL_PKT:
                begin
                    out_status_reg <= pkt_status;
                    out_answer_reg <= '0;
                end
                lsps_pkg::OSEL_ZERO:
                begin
                    out_status_reg <= lsps_pkg::STAT_ANSWER;
                    out_answer_reg <= '0;
                end
                lsps_pkg::OSEL_MEAN:
                begin
                    out_status_reg <= lsps_pkg::STAT_ANSWER;
                    out_answer_reg <= dend_reg[lsps_pkg::ANS_W-1:0];
                end
                lsps_pkg::OSEL_BEST:
                begin
                    out_status_reg <= lsps_pkg::STAT_ANSWER;
                    out_answer_reg <= {best_reg, {lsps_pkg::FRAC_W{1'b0}}};
                end
                lsps_pkg::OSEL_PIVOT:
                begin
                    out_status_reg <= lsps_pkg::STAT_ANSWER;
                    out_answer_reg <= {pivot_reg, {lsps_pkg::FRAC_W{1'b0}}};
                end
                default:
                begin
                    out_status_reg <= lsps_pkg::STAT_SKIP;
                    out_answer_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_answer = out_answer_reg;
    assign out_count  = out_count_reg;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.n_zero    = (fill_reg == '0);
    assign stat.k_zero    = (dend_reg == '0);
    assign stat.k_ge_n    = (dend_reg >= DEND_W'(fill_reg));
    assign stat.div_busy  = (dcnt_reg != '0);
    assign stat.scan_busy = scan_act_reg || scan_pend_reg;
    assign stat.hit       = ({1'b0, below_reg} <= k_val) && (k_val < {1'b0, upto_reg});

endmodule

[rtl/core/latency_sample_percentile_stats.sv]
// Packet items: result registered on acceptance, one item per cycle unless stalled.
// Mean query: quotient from the bit-serial divider, one quotient bit per cycle.
// Percentile query: the rank is formed with a reciprocal multiply, then a minimum
// or maximum scan, or a count scan per candidate pivot for the k-th value.
// Reset clears the counters, the running sum, configuration and control state; the
// sample memory is not cleared and only entries below the fill count are ever read.
`include "latency_sample_percentile_stats_assert.svh"

module latency_sample_percentile_stats
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    lsps_in_if.sink    in_ch,
    lsps_out_if.source out_ch,
    lsps_cfg_if.sink   cfg_ch
);

    lsps_pkg::cmd_t  cmd;
    lsps_pkg::stat_t stat;

    assign cfg_ch.ready = 1'b1;

    lsps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsps_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_word    (in_ch.latency_word),
        .in_pct     (in_ch.query_percent),
        .cfg_valid  (cfg_ch.valid),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_status (out_ch.status),
        .out_answer (out_ch.answer_value),
        .out_count  (out_ch.stored_count)
    );

    `LSPS_ASSERT_NEXT(a_pkt_result, in_ch.valid && in_ch.ready && in_ch.kind == lsps_pkg::KIND_PKT, out_ch.valid)
    `LSPS_ASSERT_SAME(a_count_bound, out_ch.valid, 32'(out_ch.stored_count) <= 32'(MAX_SAMPLES))
    `LSPS_ASSERT_SAME(a_pkt_no_answer, out_ch.valid && out_ch.status != lsps_pkg::STAT_ANSWER, out_ch.answer_value == '0)

endmodule
